// ----- design/mfsv_pkg.sv -----
// package: types, phase codes, error codes and field kinds of the motion file validator
package mfsv_pkg;

  localparam int PosBits = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [31:0] field_value;
    logic [31:0] record_index;
    logic [1:0]  component;
    logic [3:0]  error_code;
    logic [31:0] error_position;
    logic        last_of_run;
  } out_item_t;

  localparam logic [4:0] PH_HEADER = 5'd0;
  localparam logic [4:0] PH_MODEL = 5'd1;
  localparam logic [4:0] PH_BONE_COUNT = 5'd2;
  localparam logic [4:0] PH_BONE_NAME = 5'd3;
  localparam logic [4:0] PH_BONE_FRAME = 5'd4;
  localparam logic [4:0] PH_BONE_FLOAT = 5'd5;
  localparam logic [4:0] PH_BONE_INTERP = 5'd6;
  localparam logic [4:0] PH_MORPH_COUNT = 5'd7;
  localparam logic [4:0] PH_MORPH_NAME = 5'd8;
  localparam logic [4:0] PH_MORPH_FRAME = 5'd9;
  localparam logic [4:0] PH_MORPH_WEIGHT = 5'd10;
  localparam logic [4:0] PH_CAM_COUNT = 5'd11;
  localparam logic [4:0] PH_CAM_SKIP = 5'd12;
  localparam logic [4:0] PH_LIGHT_COUNT = 5'd13;
  localparam logic [4:0] PH_LIGHT_SKIP = 5'd14;
  localparam logic [4:0] PH_SHADOW_COUNT = 5'd15;
  localparam logic [4:0] PH_SHADOW_SKIP = 5'd16;
  localparam logic [4:0] PH_IK_COUNT = 5'd17;
  localparam logic [4:0] PH_IK_FRAME = 5'd18;
  localparam logic [4:0] PH_IK_VIS = 5'd19;
  localparam logic [4:0] PH_IK_STATES = 5'd20;
  localparam logic [4:0] PH_IK_NAME = 5'd21;
  localparam logic [4:0] PH_IK_ENABLED = 5'd22;
  localparam logic [4:0] PH_DONE = 5'd23;

  localparam logic [3:0] E_OK = 4'd0;
  localparam logic [3:0] E_TRUNC = 4'd1;
  localparam logic [3:0] E_SIG = 4'd2;
  localparam logic [3:0] E_COUNT = 4'd3;
  localparam logic [3:0] E_NONFINITE = 4'd4;
  localparam logic [3:0] E_VIS = 4'd5;
  localparam logic [3:0] E_EN = 4'd6;
  localparam logic [3:0] E_IKTOTAL = 4'd7;
  localparam logic [3:0] E_TRAIL = 4'd8;

  localparam logic [3:0] K_STATUS = 4'd0;
  localparam logic [3:0] K_BONE_COUNT = 4'd1;
  localparam logic [3:0] K_BONE_FRAME = 4'd2;
  localparam logic [3:0] K_BONE_TRANS = 4'd3;
  localparam logic [3:0] K_BONE_ROT = 4'd4;
  localparam logic [3:0] K_MORPH_COUNT = 4'd5;
  localparam logic [3:0] K_MORPH_FRAME = 4'd6;
  localparam logic [3:0] K_MORPH_WEIGHT = 4'd7;
  localparam logic [3:0] K_CAM_COUNT = 4'd8;
  localparam logic [3:0] K_LIGHT_COUNT = 4'd9;
  localparam logic [3:0] K_SHADOW_COUNT = 4'd10;
  localparam logic [3:0] K_IK_COUNT = 4'd11;
  localparam logic [3:0] K_IK_FRAME = 4'd12;
  localparam logic [3:0] K_IK_VIS = 4'd13;
  localparam logic [3:0] K_IK_STATES = 4'd14;
  localparam logic [3:0] K_IK_ENABLED = 4'd15;

  localparam logic CFG_KEYFRAME_LIMIT = 1'b0;
  localparam logic CFG_IK_STATE_LIMIT = 1'b1;

  localparam logic [37:0] SKIP_NAME = 38'd15;
  localparam logic [37:0] SKIP_MODEL = 38'd20;
  localparam logic [37:0] SKIP_INTERP = 38'd64;
  localparam logic [37:0] SKIP_IK_NAME = 38'd20;
  localparam logic [5:0] LEN_CAM = 6'd61;
  localparam logic [5:0] LEN_LIGHT = 6'd28;
  localparam logic [5:0] LEN_SHADOW = 6'd9;

  function automatic logic [7:0] sig_char(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0: c = "V";  5'd1: c = "o";  5'd2: c = "c";  5'd3: c = "a";
      5'd4: c = "l";  5'd5: c = "o";  5'd6: c = "i";  5'd7: c = "d";
      5'd8: c = " ";  5'd9: c = "M";  5'd10: c = "o"; 5'd11: c = "t";
      5'd12: c = "i"; 5'd13: c = "o"; 5'd14: c = "n"; 5'd15: c = " ";
      5'd16: c = "D"; 5'd17: c = "a"; 5'd18: c = "t"; 5'd19: c = "a";
      5'd20: c = " "; 5'd21: c = "0"; 5'd22: c = "0"; 5'd23: c = "0";
      5'd24: c = "2";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- design/mfsv_out_buf.sv -----
// four-entry output queue taking up to two result items per accepted byte
module mfsv_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push0,
  input  logic                push1,
  input  mfsv_pkg::out_item_t item0,
  input  mfsv_pkg::out_item_t item1,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output mfsv_pkg::out_item_t out_data
);

  mfsv_pkg::out_item_t q_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic pop;

  assign out_valid = cnt_r != 3'd0;
  assign out_data  = q_r[rd_r];
  assign pop       = out_valid && out_ready;
  // room for two more pushes; this cycle's pop is not counted
  assign has_room  = cnt_r <= 3'd2;

  always_comb begin
    cnt_nxt = cnt_r + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
      wr_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) rd_r <= rd_r + 2'd1;
      if (push0 && push1) wr_r <= wr_r + 2'd2;
      else if (push0) wr_r <= wr_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) q_r[wr_r] <= item0;
    if (push1) q_r[wr_r + 2'd1] <= item1;
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue overflow");
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n) push1 |-> push0)
    else $error("second push without first");
  a_room: assert property (@(posedge clk) disable iff (!rst_n) push0 |-> cnt_r <= 3'd2)
    else $error("push without room");

endmodule

// ----- design/motion_file_stream_validator_top.sv -----
// top level of the motion file stream validator
// usage:
//   in channel: one item per file byte (in_data.data_byte with byte_present set),
//   end_of_file marks the last item; an item may carry only the end mark.
//   out channel: zero, one or two result items per input item, each a finished
//   count, frame, float or flag, and a final status item ending the run.
//   cfg port: cfg_we with cfg_index 0 (keyframe limit) or 1 (ik state limit),
//   written only while the block is idle.
// an item's results are pushed into the result queue as the item is accepted.
// throughput: one byte per cycle when in_ready is high; parser state updates in
//   one pass of short logic (byte shift, counter compare, one 32x6 product).
// a four-entry result queue sits between parser and out channel; the parser
//   takes a byte whenever two entries are free, so a stalled receiver only
//   stops input once fewer than two entries are free.
// reset: synchronous rst_n clears parser state and restores both limits to
//   1048576; the queue empties.
// after the status item every later input item is swallowed until reset.
module motion_file_stream_validator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfsv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfsv_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int PB = mfsv_pkg::PosBits;

  logic [31:0] kf_limit_r, ik_limit_r;
  logic [4:0] phase_r, phase_nxt;
  logic [PB-1:0] pos_r, pos_nxt, fstart_r, fstart_nxt;
  logic [4:0] bif_r, bif_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] rc_r, rc_nxt, rt_r, rt_nxt;
  logic [2:0] comp_r, comp_nxt;
  logic [37:0] skip_r, skip_nxt;
  logic [32:0] ikt_r, ikt_nxt;
  logic [31:0] isc_r, isc_nxt, ist_r, ist_nxt;
  logic sigmis_r, sigmis_nxt, err_r, err_nxt;

  logic take;
  logic push0, push1, room;
  mfsv_pkg::out_item_t item0, item1;

  assign in_ready = room;
  assign take = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kf_limit_r <= 32'd1048576;
      ik_limit_r <= 32'd1048576;
    end else if (cfg_we) begin
      if (cfg_index == mfsv_pkg::CFG_KEYFRAME_LIMIT) kf_limit_r <= cfg_wdata;
      else ik_limit_r <= cfg_wdata;
    end
  end

  // result slots: n counts items emitted this byte
  logic [1:0] n;
  mfsv_pkg::out_item_t e0, e1;

  always_comb begin
    logic [7:0] b;
    logic [31:0] w;
    logic [PB-1:0] prev_pos;
    logic [37:0] sk;
    logic [37:0] prod;
    logic [2:0] c;
    logic bnd;
    logic [31:0] rcp;
    logic [31:0] iscp;

    phase_nxt = phase_r; pos_nxt = pos_r; fstart_nxt = fstart_r; bif_nxt = bif_r;
    shift_nxt = shift_r; rc_nxt = rc_r; rt_nxt = rt_r; comp_nxt = comp_r;
    skip_nxt = skip_r; ikt_nxt = ikt_r; isc_nxt = isc_r; ist_nxt = ist_r;
    sigmis_nxt = sigmis_r; err_nxt = err_r;
    n = 2'd0; e0 = '0; e1 = '0;
    b = in_data.data_byte;
    prev_pos = pos_r;
    w = shift_r | ({24'd0, b} << {bif_r[1:0], 3'b000});
    sk = '0; prod = '0; c = '0; bnd = 1'b0;
    rcp = rc_r + 32'd1;
    iscp = isc_r + 32'd1;

    if (take && !err_r) begin
      if (in_data.byte_present) begin
        pos_nxt = pos_r + 1'b1;
        unique case (phase_r)
          mfsv_pkg::PH_DONE: begin
            e0.error_code = mfsv_pkg::E_TRAIL; e0.error_position = 32'(prev_pos);
            n = 2'd1; err_nxt = 1'b1;
          end
          mfsv_pkg::PH_HEADER: begin
            if (bif_r < 5'd25 && b != mfsv_pkg::sig_char(bif_r)) sigmis_nxt = 1'b1;
            bif_nxt = bif_r + 5'd1;
            if (bif_r == 5'd29) begin
              if (sigmis_nxt) begin
                e0.error_code = mfsv_pkg::E_SIG; n = 2'd1; err_nxt = 1'b1;
              end else begin
                phase_nxt = mfsv_pkg::PH_MODEL; fstart_nxt = pos_nxt; bif_nxt = '0;
                shift_nxt = '0; skip_nxt = mfsv_pkg::SKIP_MODEL;
              end
            end
          end
          mfsv_pkg::PH_MODEL, mfsv_pkg::PH_BONE_NAME, mfsv_pkg::PH_BONE_INTERP,
          mfsv_pkg::PH_MORPH_NAME, mfsv_pkg::PH_CAM_SKIP, mfsv_pkg::PH_LIGHT_SKIP,
          mfsv_pkg::PH_SHADOW_SKIP, mfsv_pkg::PH_IK_NAME: begin
            sk = (skip_r != '0) ? skip_r - 38'd1 : skip_r;
            skip_nxt = sk;
            if (sk == '0) begin
              fstart_nxt = pos_nxt; bif_nxt = '0; shift_nxt = '0;
              priority case (phase_r)
                mfsv_pkg::PH_MODEL: phase_nxt = mfsv_pkg::PH_BONE_COUNT;
                mfsv_pkg::PH_BONE_NAME: phase_nxt = mfsv_pkg::PH_BONE_FRAME;
                mfsv_pkg::PH_BONE_INTERP: begin
                  rc_nxt = rcp;
                  if (rcp == rt_r) phase_nxt = mfsv_pkg::PH_MORPH_COUNT;
                  else begin
                    phase_nxt = mfsv_pkg::PH_BONE_NAME; skip_nxt = mfsv_pkg::SKIP_NAME;
                  end
                end
                mfsv_pkg::PH_MORPH_NAME: phase_nxt = mfsv_pkg::PH_MORPH_FRAME;
                mfsv_pkg::PH_CAM_SKIP: phase_nxt = mfsv_pkg::PH_LIGHT_COUNT;
                mfsv_pkg::PH_LIGHT_SKIP: phase_nxt = mfsv_pkg::PH_SHADOW_COUNT;
                mfsv_pkg::PH_SHADOW_SKIP: phase_nxt = mfsv_pkg::PH_IK_COUNT;
                default: phase_nxt = mfsv_pkg::PH_IK_ENABLED;
              endcase
            end
          end
          mfsv_pkg::PH_IK_VIS: begin
            e0.field_kind = mfsv_pkg::K_IK_VIS; e0.field_value = {24'd0, b};
            e0.record_index = rc_r; n = 2'd1;
            if (b > 8'd1) begin
              e1.error_code = mfsv_pkg::E_VIS; e1.error_position = 32'(pos_nxt);
              n = 2'd2; err_nxt = 1'b1;
            end else begin
              phase_nxt = mfsv_pkg::PH_IK_STATES; fstart_nxt = pos_nxt;
              bif_nxt = '0; shift_nxt = '0;
            end
          end
          mfsv_pkg::PH_IK_ENABLED: begin
            e0.field_kind = mfsv_pkg::K_IK_ENABLED; e0.field_value = {24'd0, b};
            e0.record_index = isc_r; n = 2'd1;
            if (b > 8'd1) begin
              e1.error_code = mfsv_pkg::E_EN; e1.error_position = 32'(pos_nxt);
              n = 2'd2; err_nxt = 1'b1;
            end else begin
              isc_nxt = iscp; fstart_nxt = pos_nxt; bif_nxt = '0; shift_nxt = '0;
              if (iscp == ist_r) begin
                rc_nxt = rcp;
                phase_nxt = (rcp == rt_r) ? mfsv_pkg::PH_DONE : mfsv_pkg::PH_IK_FRAME;
              end else begin
                phase_nxt = mfsv_pkg::PH_IK_NAME; skip_nxt = mfsv_pkg::SKIP_IK_NAME;
              end
            end
          end
          default: begin
            // word field: gather four bytes
            shift_nxt = w;
            bif_nxt = bif_r + 5'd1;
            if (bif_r == 5'd3) begin
              n = 2'd1;
              e0.field_value = w;
              fstart_nxt = pos_nxt; bif_nxt = '0; shift_nxt = '0;
              priority case (phase_r)
                mfsv_pkg::PH_BONE_COUNT, mfsv_pkg::PH_MORPH_COUNT, mfsv_pkg::PH_CAM_COUNT,
                mfsv_pkg::PH_LIGHT_COUNT, mfsv_pkg::PH_SHADOW_COUNT,
                mfsv_pkg::PH_IK_COUNT: begin
                  priority case (phase_r)
                    mfsv_pkg::PH_BONE_COUNT: e0.field_kind = mfsv_pkg::K_BONE_COUNT;
                    mfsv_pkg::PH_MORPH_COUNT: e0.field_kind = mfsv_pkg::K_MORPH_COUNT;
                    mfsv_pkg::PH_CAM_COUNT: e0.field_kind = mfsv_pkg::K_CAM_COUNT;
                    mfsv_pkg::PH_LIGHT_COUNT: e0.field_kind = mfsv_pkg::K_LIGHT_COUNT;
                    mfsv_pkg::PH_SHADOW_COUNT: e0.field_kind = mfsv_pkg::K_SHADOW_COUNT;
                    default: e0.field_kind = mfsv_pkg::K_IK_COUNT;
                  endcase
                  if (w > kf_limit_r) begin
                    e1.error_code = mfsv_pkg::E_COUNT; e1.error_position = 32'(pos_nxt);
                    n = 2'd2; err_nxt = 1'b1;
                    fstart_nxt = fstart_r; bif_nxt = bif_r + 5'd1; shift_nxt = w;
                  end else begin
                    rt_nxt = w; rc_nxt = '0;
                    priority case (phase_r)
                      mfsv_pkg::PH_CAM_COUNT: prod = 38'(w) * 38'(mfsv_pkg::LEN_CAM);
                      mfsv_pkg::PH_LIGHT_COUNT: prod = 38'(w) * 38'(mfsv_pkg::LEN_LIGHT);
                      default: prod = 38'(w) * 38'(mfsv_pkg::LEN_SHADOW);
                    endcase
                    priority case (phase_r)
                      mfsv_pkg::PH_BONE_COUNT: begin
                        if (w == '0) phase_nxt = mfsv_pkg::PH_MORPH_COUNT;
                        else begin
                          phase_nxt = mfsv_pkg::PH_BONE_NAME; skip_nxt = mfsv_pkg::SKIP_NAME;
                        end
                      end
                      mfsv_pkg::PH_MORPH_COUNT: begin
                        if (w == '0) phase_nxt = mfsv_pkg::PH_CAM_COUNT;
                        else begin
                          phase_nxt = mfsv_pkg::PH_MORPH_NAME;
                          skip_nxt = mfsv_pkg::SKIP_NAME;
                        end
                      end
                      mfsv_pkg::PH_CAM_COUNT: begin
                        if (w == '0) phase_nxt = mfsv_pkg::PH_LIGHT_COUNT;
                        else begin phase_nxt = mfsv_pkg::PH_CAM_SKIP; skip_nxt = prod; end
                      end
                      mfsv_pkg::PH_LIGHT_COUNT: begin
                        if (w == '0) phase_nxt = mfsv_pkg::PH_SHADOW_COUNT;
                        else begin phase_nxt = mfsv_pkg::PH_LIGHT_SKIP; skip_nxt = prod; end
                      end
                      mfsv_pkg::PH_SHADOW_COUNT: begin
                        if (w == '0) phase_nxt = mfsv_pkg::PH_IK_COUNT;
                        else begin
                          phase_nxt = mfsv_pkg::PH_SHADOW_SKIP; skip_nxt = prod;
                        end
                      end
                      default: phase_nxt = (w == '0) ? mfsv_pkg::PH_DONE
                                                     : mfsv_pkg::PH_IK_FRAME;
                    endcase
                  end
                end
                mfsv_pkg::PH_BONE_FRAME: begin
                  e0.field_kind = mfsv_pkg::K_BONE_FRAME; e0.record_index = rc_r;
                  phase_nxt = mfsv_pkg::PH_BONE_FLOAT; comp_nxt = '0;
                end
                mfsv_pkg::PH_BONE_FLOAT: begin
                  c = comp_r;
                  e0.record_index = rc_r;
                  if (c < 3'd3) begin
                    e0.field_kind = mfsv_pkg::K_BONE_TRANS; e0.component = c[1:0];
                  end else begin
                    e0.field_kind = mfsv_pkg::K_BONE_ROT; e0.component = 2'(c - 3'd3);
                  end
                  if (w[30:23] == 8'hff) begin
                    e1.error_code = mfsv_pkg::E_NONFINITE; e1.error_position = 32'(pos_nxt);
                    n = 2'd2; err_nxt = 1'b1;
                    fstart_nxt = fstart_r; bif_nxt = bif_r + 5'd1; shift_nxt = w;
                  end else if (c >= 3'd6) begin
                    phase_nxt = mfsv_pkg::PH_BONE_INTERP; skip_nxt = mfsv_pkg::SKIP_INTERP;
                  end else begin
                    comp_nxt = c + 3'd1;
                  end
                end
                mfsv_pkg::PH_MORPH_FRAME: begin
                  e0.field_kind = mfsv_pkg::K_MORPH_FRAME; e0.record_index = rc_r;
                  phase_nxt = mfsv_pkg::PH_MORPH_WEIGHT;
                end
                mfsv_pkg::PH_MORPH_WEIGHT: begin
                  e0.field_kind = mfsv_pkg::K_MORPH_WEIGHT; e0.record_index = rc_r;
                  if (w[30:23] == 8'hff) begin
                    e1.error_code = mfsv_pkg::E_NONFINITE; e1.error_position = 32'(pos_nxt);
                    n = 2'd2; err_nxt = 1'b1;
                    fstart_nxt = fstart_r; bif_nxt = bif_r + 5'd1; shift_nxt = w;
                  end else begin
                    rc_nxt = rcp;
                    if (rcp == rt_r) phase_nxt = mfsv_pkg::PH_CAM_COUNT;
                    else begin
                      phase_nxt = mfsv_pkg::PH_MORPH_NAME; skip_nxt = mfsv_pkg::SKIP_NAME;
                    end
                  end
                end
                mfsv_pkg::PH_IK_FRAME: begin
                  e0.field_kind = mfsv_pkg::K_IK_FRAME; e0.record_index = rc_r;
                  phase_nxt = mfsv_pkg::PH_IK_VIS;
                end
                default: begin
                  e0.field_kind = mfsv_pkg::K_IK_STATES; e0.record_index = rc_r;
                  ikt_nxt = ikt_r + {1'b0, w};
                  if (ikt_nxt > {1'b0, ik_limit_r}) begin
                    e1.error_code = mfsv_pkg::E_IKTOTAL; e1.error_position = 32'(pos_nxt);
                    n = 2'd2; err_nxt = 1'b1;
                    fstart_nxt = fstart_r; bif_nxt = bif_r + 5'd1; shift_nxt = w;
                  end else begin
                    ist_nxt = w; isc_nxt = '0;
                    if (w == '0) begin
                      rc_nxt = rcp;
                      phase_nxt = (rcp == rt_r) ? mfsv_pkg::PH_DONE : mfsv_pkg::PH_IK_FRAME;
                    end else begin
                      phase_nxt = mfsv_pkg::PH_IK_NAME; skip_nxt = mfsv_pkg::SKIP_IK_NAME;
                    end
                  end
                end
              endcase
            end
          end
        endcase
      end
      // end of file status
      if (!err_nxt && in_data.end_of_file) begin
        bnd = phase_nxt == mfsv_pkg::PH_DONE ||
              (bif_nxt == '0 && (phase_nxt == mfsv_pkg::PH_MORPH_COUNT ||
               phase_nxt == mfsv_pkg::PH_CAM_COUNT || phase_nxt == mfsv_pkg::PH_LIGHT_COUNT ||
               phase_nxt == mfsv_pkg::PH_SHADOW_COUNT || phase_nxt == mfsv_pkg::PH_IK_COUNT));
        err_nxt = 1'b1;
        if (n == 2'd0) begin
          e0.error_code = bnd ? mfsv_pkg::E_OK : mfsv_pkg::E_TRUNC;
          e0.error_position = bnd ? 32'(pos_nxt) : 32'(fstart_nxt);
          n = 2'd1;
        end else begin
          e1.error_code = bnd ? mfsv_pkg::E_OK : mfsv_pkg::E_TRUNC;
          e1.error_position = bnd ? 32'(pos_nxt) : 32'(fstart_nxt);
          n = 2'd2;
        end
      end
      if (n == 2'd1) e0.last_of_run = 1'b1;
      if (n == 2'd2) e1.last_of_run = 1'b1;
    end
  end

  assign push0 = n != 2'd0;
  assign push1 = n == 2'd2;
  assign item0 = e0;
  assign item1 = e1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mfsv_pkg::PH_HEADER;
      pos_r <= '0; fstart_r <= '0; bif_r <= '0; shift_r <= '0;
      rc_r <= '0; rt_r <= '0; comp_r <= '0; skip_r <= '0; ikt_r <= '0;
      isc_r <= '0; ist_r <= '0; sigmis_r <= 1'b0; err_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r <= pos_nxt; fstart_r <= fstart_nxt; bif_r <= bif_nxt; shift_r <= shift_nxt;
      rc_r <= rc_nxt; rt_r <= rt_nxt; comp_r <= comp_nxt; skip_r <= skip_nxt;
      ikt_r <= ikt_nxt; isc_r <= isc_nxt; ist_r <= ist_nxt;
      sigmis_r <= sigmis_nxt; err_r <= err_nxt;
    end
  end

  mfsv_out_buf u_buf (
    .clk(clk), .rst_n(rst_n), .push0(push0), .push1(push1),
    .item0(item0), .item1(item1), .has_room(room),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // once the status is out, nothing more is produced
  a_silent: assert property (@(posedge clk) disable iff (!rst_n) err_r |-> !push0)
    else $error("result after status");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n) err_r |=> err_r)
    else $error("error latch dropped");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n) phase_r <= mfsv_pkg::PH_DONE)
    else $error("phase out of range");
  a_bif: assert property (@(posedge clk) disable iff (!rst_n) bif_r <= 5'd30)
    else $error("byte count out of range");

endmodule
